@@ hdl/change_notify_throttle_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the change-notification throttle
// Shared concurrent check wrappers, clocked on the rising edge.
// ---------------------------------------------------------------------------
`ifndef CHANGE_NOTIFY_THROTTLE_UNIT_MACROS_SVH
`define CHANGE_NOTIFY_THROTTLE_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CNT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define CNT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/cnt_pkg.sv @@
// ---------------------------------------------------------------------------
// Change-notification throttle package
// Types, register indexes and fixed constants shared by the block.
// ---------------------------------------------------------------------------
package cnt_pkg;

   localparam int SLOT_W  = 4;
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 32;
   localparam int CSR_W   = 2;

   // smoothing window: lower edge and margin above the longest smoother
   localparam logic [TIME_W-1:0] WIN_LOW_US    = 32'd1000;
   localparam logic [TIME_W:0]   WIN_MARGIN_US = 33'd1100;

   // configuration register indexes
   localparam logic [CSR_W-1:0] CSR_MIN_INTERVAL = 2'd0;
   localparam logic [CSR_W-1:0] CSR_LONGEST_SMOO = 2'd1;
   localparam logic [CSR_W-1:0] CSR_SMOOTHERS    = 2'd2;

   // operation codes
   localparam logic OP_STORE   = 1'b0;
   localparam logic OP_PROCESS = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SWEEP  = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] min_interval;
      logic [TIME_W-1:0] longest_smoothing;
      logic              smoothers;
   } cfg_type;

   // sequencer to decision logic
   typedef struct packed {
      logic              start;
      logic              changed;
      logic              commit;
      logic              touch;
      logic [TIME_W-1:0] now;
   } ctl_type;

   typedef struct packed {
      logic               fire;
      logic [TIME_W-1:0]  interval;
      logic [COUNT_W-1:0] count;
   } res_type;

endpackage

@@ hdl/cnt_serial_store.sv @@
// ---------------------------------------------------------------------------
// Serial store
// Latest and saved serial memories with a compare-and-copy sweep port.
// ---------------------------------------------------------------------------
module cnt_serial_store #(
   parameter int SLOTS       = 16,
   parameter int SERIAL_BITS = 32,
   parameter int AW          = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [SERIAL_BITS-1:0] wr_data,
   input  logic                   sweep_en,
   input  logic [AW-1:0]          sweep_addr,
   output logic                   changed
);

   logic [SERIAL_BITS-1:0] latest_mem [SLOTS];
   logic [SERIAL_BITS-1:0] saved_mem  [SLOTS];

   logic [SLOTS-1:0]       latest_vld_ff, latest_vld_in;
   logic [SLOTS-1:0]       saved_vld_ff, saved_vld_in;

   logic [SERIAL_BITS-1:0] lat_rd_ff, sav_rd_ff;
   logic                   lat_rv_ff, sav_rv_ff, lat_rv_in, sav_rv_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [AW-1:0]          rd_addr_ff;

   logic [SERIAL_BITS-1:0] lat_val, sav_val;

   // entries never written read as zero
   assign lat_val = lat_rv_ff ? lat_rd_ff : '0;
   assign sav_val = sav_rv_ff ? sav_rd_ff : '0;
   assign changed = rd_valid_ff && (lat_val != sav_val);

   // valid bits
   always_comb begin
      latest_vld_in = latest_vld_ff;
      saved_vld_in  = saved_vld_ff;
      if (wr_en) begin
         latest_vld_in[wr_addr] = 1'b1;
      end
      if (rd_valid_ff) begin
         saved_vld_in[rd_addr_ff] = 1'b1;
      end
      lat_rv_in   = latest_vld_ff[sweep_addr];
      sav_rv_in   = saved_vld_ff[sweep_addr];
      rd_valid_in = sweep_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latest_vld_ff <= '0;
         saved_vld_ff  <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         latest_vld_ff <= latest_vld_in;
         saved_vld_ff  <= saved_vld_in;
         rd_valid_ff   <= rd_valid_in;
      end
   end

   // latest serials: written by store transactions, read by the sweep
   always_ff @(posedge clock) begin
      if (wr_en) begin
         latest_mem[wr_addr] <= wr_data;
      end
      lat_rd_ff <= latest_mem[sweep_addr];
      lat_rv_ff <= lat_rv_in;
   end

   // saved serials: read by the sweep, copied back one slot behind
   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         saved_mem[rd_addr_ff] <= lat_val;
      end
      sav_rd_ff  <= saved_mem[sweep_addr];
      sav_rv_ff  <= sav_rv_in;
      rd_addr_ff <= sweep_addr;
   end

endmodule

@@ hdl/cnt_fire_logic.sv @@
// ---------------------------------------------------------------------------
// Fire decision
// Time accumulator, smoothing window and fire/retry decision state.
// ---------------------------------------------------------------------------
`include "change_notify_throttle_unit_macros.svh"

module cnt_fire_logic (
   input  logic             clock,
   input  logic             reset,
   input  cnt_pkg::cfg_type cfg,
   input  cnt_pkg::ctl_type ctl,
   output cnt_pkg::res_type res
);

   localparam int TW = cnt_pkg::TIME_W;
   localparam int CW = cnt_pkg::COUNT_W;

   logic [TW-1:0] now_ff, acc_ff, lct_ff, lft_ff;
   logic [TW-1:0] now_in, acc_in, lct_in, lft_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          touch_ff, win_ff, pending_ff, extra_ff;
   logic          touch_in, win_in, pending_in, extra_in;

   logic [TW-1:0] since_fire, since_change;
   logic [TW:0]   acc_sum, win_hi;
   logic [TW-1:0] acc_sat;
   logic          win_now, recompute0, attempt, fire_ok;

   // start of a tick: accumulate and test the smoothing window
   always_comb begin
      since_fire   = ctl.now - lft_ff;
      acc_sum      = {1'b0, acc_ff} + {1'b0, since_fire};
      acc_sat      = acc_sum[TW] ? '1 : acc_sum[TW-1:0];
      since_change = ctl.now - lct_ff;
      win_hi       = {1'b0, cfg.longest_smoothing} + cnt_pkg::WIN_MARGIN_US;
      win_now      = (since_change >= cnt_pkg::WIN_LOW_US) &&
                     ({1'b0, since_change} <= win_hi);
   end

   // decision from the state left by the sweep; the count only moves on commit
   always_comb begin
      recompute0   = pending_ff | win_ff;
      attempt      = recompute0 | extra_ff | touch_ff;
      fire_ok      = attempt && (acc_ff >= cfg.min_interval);
      res.fire     = fire_ok;
      res.interval = fire_ok ? (now_ff - lft_ff) : '0;
      res.count    = cnt_ff + CW'(fire_ok && ctl.commit);
   end

   always_comb begin
      now_in     = now_ff;
      touch_in   = touch_ff;
      win_in     = win_ff;
      acc_in     = acc_ff;
      lct_in     = lct_ff;
      lft_in     = lft_ff;
      cnt_in     = cnt_ff;
      pending_in = pending_ff;
      extra_in   = extra_ff;
      if (ctl.start) begin
         now_in   = ctl.now;
         touch_in = ctl.touch;
         win_in   = win_now;
         acc_in   = acc_sat;
      end
      if (ctl.changed) begin
         pending_in = 1'b1;
         extra_in   = cfg.smoothers;
      end
      if (ctl.commit) begin
         if (fire_ok) begin
            if (pending_ff) begin
               lct_in = now_ff;
            end
            pending_in = 1'b0;
            acc_in     = '0;
            lft_in     = now_ff;
            cnt_in     = res.count;
         end
         // a held-back attempt is retried; a spent extra recompute clears
         priority if (attempt && !fire_ok) begin
            extra_in = 1'b1;
         end else if (!recompute0 && extra_ff) begin
            extra_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         lct_ff     <= '0;
         lft_ff     <= '0;
         cnt_ff     <= '0;
         pending_ff <= 1'b0;
         extra_ff   <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         lct_ff     <= lct_in;
         lft_ff     <= lft_in;
         cnt_ff     <= cnt_in;
         pending_ff <= pending_in;
         extra_ff   <= extra_in;
      end
   end

   // tick payload
   always_ff @(posedge clock) begin
      now_ff   <= now_in;
      touch_ff <= touch_in;
      win_ff   <= win_in;
   end

   `CNT_ASSERT_NEXT(a_fire_counts, clock, reset, ctl.commit && fire_ok, cnt_ff == $past(cnt_ff) + CW'(1), "fire did not advance counter")
   `CNT_ASSERT_NEXT(a_fire_clears, clock, reset, ctl.commit && fire_ok, acc_ff == '0 && !pending_ff, "fire left accumulator or pending set")
   `CNT_ASSERT_NEXT(a_retry_armed, clock, reset, ctl.commit && attempt && !fire_ok, extra_ff, "held-back attempt not armed for retry")

endmodule

@@ hdl/change_notify_throttle_unit.sv @@
// ---------------------------------------------------------------------------
// Change-notification throttle
// Compares stored source serials on every tick and rate-limits fires.
// ---------------------------------------------------------------------------
//  channel  direction  tdata (low bit first)                    tuser
//  req_     in         slot, source_serial, update_time_us,     operation
//                      touch, zero fill
//  rsp_     out        fire_interval_us, fire_count             fire
//  csr_     in         csr_index selects register, csr_data     -
//
//  A store transaction steps through accept, then result load.
//  A process transaction steps through accept, one sweep step per slot
//  reading both serial memories, a drain step for the last read, one decision.
//  The serial memory read port sets the sweep rate: one slot per cycle.
//  A new request is accepted while a result waits; the decision and the
//  store result wait for the output register to free. Reset is synchronous,
//  active high; serial memories read as zero until written.
// ---------------------------------------------------------------------------
`include "change_notify_throttle_unit_macros.svh"

module change_notify_throttle_unit #(
   parameter int SLOTS       = 16,
   parameter int SERIAL_BITS = 32,
   localparam int REQ_W      = ((cnt_pkg::SLOT_W + SERIAL_BITS + cnt_pkg::TIME_W + 1 + 7)
                                / 8) * 8,
   localparam int RSP_W      = cnt_pkg::TIME_W + cnt_pkg::COUNT_W
) (
   input  logic                             clock,
   input  logic                             reset,
   // slot[3:0], source_serial, update_time_us, touch, zero fill
   input  logic [REQ_W-1:0]                 req_tdata,
   // operation
   input  logic                             req_tuser,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // fire_interval_us[31:0], fire_count[63:32]
   output logic [RSP_W-1:0]                 rsp_tdata,
   // fire
   output logic                             rsp_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [cnt_pkg::CSR_W-1:0]        csr_index,
   input  logic [cnt_pkg::TIME_W-1:0]       csr_data,
   input  logic                             csr_valid,
   output logic                             csr_ready
);

   localparam int TW    = cnt_pkg::TIME_W;
   localparam int SW    = cnt_pkg::SLOT_W;
   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SER_LO = SW;
   localparam int NOW_LO = SW + SERIAL_BITS;
   localparam int TCH_B  = SW + SERIAL_BITS + TW;

   cnt_pkg::state_type state_ff, state_in;
   cnt_pkg::cfg_type   cfg_ff, cfg_in;
   cnt_pkg::ctl_type   ctl;
   cnt_pkg::res_type   res;

   logic [AW-1:0]      sweep_ff, sweep_in;
   logic               sweep_last;
   logic               req_acc, out_free, load_dec, load_store;
   logic               store_en, changed;
   logic [SW-1:0]      req_slot;

   logic               rsp_valid_ff, rsp_valid_in;
   cnt_pkg::res_type   rsp_ff, rsp_in;

   assign req_slot   = req_tdata[SW-1:0];
   assign req_tready = (state_ff == cnt_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign sweep_last = (sweep_ff == AW'(SLOTS - 1));
   assign csr_ready  = 1'b1;

   // stores outside the slot range are dropped
   assign store_en = req_acc && (req_tuser == cnt_pkg::OP_STORE) &&
                     (32'(req_slot) < SLOTS);

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cnt_pkg::CSR_MIN_INTERVAL: cfg_in.min_interval      = csr_data;
            cnt_pkg::CSR_LONGEST_SMOO: cfg_in.longest_smoothing = csr_data;
            cnt_pkg::CSR_SMOOTHERS:    cfg_in.smoothers         = csr_data[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      sweep_in   = sweep_ff;
      load_dec   = 1'b0;
      load_store = 1'b0;
      unique case (state_ff)
         cnt_pkg::ST_IDLE: begin
            sweep_in = '0;
            if (req_acc) begin
               state_in = (req_tuser == cnt_pkg::OP_PROCESS) ?
                          cnt_pkg::ST_SWEEP : cnt_pkg::ST_RESULT;
            end
         end
         cnt_pkg::ST_SWEEP: begin
            sweep_in = sweep_ff + AW'(1);
            if (sweep_last) begin
               state_in = cnt_pkg::ST_DRAIN;
            end
         end
         cnt_pkg::ST_DRAIN: begin
            state_in = cnt_pkg::ST_DECIDE;
         end
         cnt_pkg::ST_DECIDE: begin
            if (out_free) begin
               load_dec = 1'b1;
               state_in = cnt_pkg::ST_IDLE;
            end
         end
         cnt_pkg::ST_RESULT: begin
            if (out_free) begin
               load_store = 1'b1;
               state_in   = cnt_pkg::ST_IDLE;
            end
         end
         default: state_in = cnt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl.start   = req_acc && (req_tuser == cnt_pkg::OP_PROCESS);
      ctl.changed = changed;
      ctl.commit  = load_dec;
      ctl.touch   = req_tdata[TCH_B];
      ctl.now     = req_tdata[NOW_LO +: TW];
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (load_dec) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (load_store) begin
         rsp_valid_in    = 1'b1;
         rsp_in.fire     = 1'b0;
         rsp_in.interval = '0;
         rsp_in.count    = res.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cnt_pkg::ST_IDLE;
         sweep_ff     <= '0;
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.fire;
   assign rsp_tdata  = {rsp_ff.count, rsp_ff.interval};

   cnt_serial_store #(
      .SLOTS       (SLOTS),
      .SERIAL_BITS (SERIAL_BITS),
      .AW          (AW)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (store_en),
      .wr_addr    (AW'(req_slot)),
      .wr_data    (req_tdata[SER_LO +: SERIAL_BITS]),
      .sweep_en   (state_ff == cnt_pkg::ST_SWEEP),
      .sweep_addr (sweep_ff),
      .changed    (changed)
   );

   cnt_fire_logic u_fire (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .ctl   (ctl),
      .res   (res)
   );

   `CNT_ASSERT_NEXT(a_sweep_steps, clock, reset, state_ff == cnt_pkg::ST_SWEEP && !sweep_last, state_ff == cnt_pkg::ST_SWEEP && sweep_ff == AW'($past(sweep_ff) + AW'(1)), "sweep did not step one slot")
   `CNT_ASSERT_SAME(a_no_change_idle, clock, reset, changed, state_ff == cnt_pkg::ST_SWEEP || state_ff == cnt_pkg::ST_DRAIN, "serial change reported outside the sweep")
   `CNT_ASSERT_NEXT(a_load_sets_valid, clock, reset, load_dec || load_store, rsp_valid_ff && state_ff == cnt_pkg::ST_IDLE, "result load did not reach the output")

endmodule
